[design/ps2mtc_pkg.sv]
// Shared types, constants and a helper function for the PS/2 mouse text cursor.
// Used by every module of the block but ps2mtc_ram; depends on nothing.

package ps2mtc_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = 2048;

    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int WORD_W = 16;
    localparam int MOT_W  = 6;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [COL_W-1:0]  COL_RESET   = COL_W'(40);
    localparam logic [ROW_W-1:0]  ROW_RESET   = ROW_W'(12);
    localparam logic [WORD_W-1:0] BLANK_CELL  = 16'h0720;
    localparam logic [WORD_W-1:0] CURSOR_CELL = 16'h7020;
    localparam logic [7:0]        RIGHT_ATTR  = 8'h40;
    localparam logic [7:0]        PAINT_RESET = 8'hE0;

    // Command kinds passed from the front end to the back end
    localparam logic CMD_HOST = 1'b1;
    localparam logic CMD_PKT  = 1'b0;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [2:0]        buttons;   // middle, right, left
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Nine-bit signed motion divided by ten, truncated toward zero.
    // The magnitude is at most 256, for which multiplying by 205/2048 is exact.
    function automatic logic signed [MOT_W-1:0] motion_div10(input logic [7:0] b,
                                                             input logic neg);
        logic [8:0]       mag;
        logic [16:0]      prod;
        logic [MOT_W-1:0] q;
        mag  = neg ? (9'd256 - {1'b0, b}) : {1'b0, b};
        prod = 17'(mag) * 17'd205;
        q    = prod[16:11];
        return neg ? $signed(-q) : $signed(q);
    endfunction

endpackage

[design/ps2mtc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.

module ps2mtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/ps2mtc_front.sv]
// Front end: takes input words, assembles mouse packets, moves the cursor
// and queues host writes and packet commands. Depends on ps2mtc_pkg.

module ps2mtc_front import ps2mtc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  q_status_t           q_status,
    input  logic                clear_busy,
    output logic                q_push,
    output cmd_t                q_cmd
);

    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_X    = 2'd1;
    localparam logic [1:0] PH_Y    = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       header_reg, header_next;
    logic [7:0]       xbyte_reg, xbyte_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic                    accept;
    logic [7:0]              mouse_b;
    logic signed [MOT_W-1:0] dx, dy;
    logic signed [COL_W+1:0] col_sum;
    logic signed [ROW_W+1:0] row_diff;
    logic [COL_W-1:0]        col_new;
    logic [ROW_W-1:0]        row_new;
    logic [IDX_W-1:0]        idx_new;

    assign s_tready = !q_status.full && !clear_busy;
    assign accept   = s_tvalid && s_tready;
    assign mouse_b  = s_tdata[7:0];

    assign dx = motion_div10(xbyte_reg, header_reg[4]);
    assign dy = motion_div10(mouse_b, header_reg[5]);

    assign col_sum  = $signed({2'b00, col_reg})
                      + $signed({{(COL_W+2-MOT_W){dx[MOT_W-1]}}, dx});
    assign row_diff = $signed({2'b00, row_reg})
                      - $signed({{(ROW_W+2-MOT_W){dy[MOT_W-1]}}, dy});

    always_comb begin
        if (col_sum < 0) begin
            col_new = '0;
        end else if (col_sum > (COLUMNS - 1)) begin
            col_new = COL_W'(COLUMNS - 1);
        end else begin
            col_new = col_sum[COL_W-1:0];
        end
        if (row_diff < 0) begin
            row_new = '0;
        end else if (row_diff > (ROWS - 1)) begin
            row_new = ROW_W'(ROWS - 1);
        end else begin
            row_new = row_diff[ROW_W-1:0];
        end
    end

    // The store size is a power of two, so wrapping is a truncation.
    assign idx_new = IDX_W'(int'(row_new) * COLUMNS + int'(col_new));

    always_comb begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xbyte_next  = xbyte_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        q_push      = 1'b0;
        q_cmd       = '0;
        if (accept) begin
            if (s_tuser == CMD_HOST) begin
                q_push     = 1'b1;
                q_cmd.kind = CMD_HOST;
                q_cmd.idx  = s_tdata[18:8];
                q_cmd.word = s_tdata[34:19];
            end else begin
                case (phase_reg)
                    PH_X: begin
                        xbyte_next = mouse_b;
                        phase_next = PH_Y;
                    end
                    PH_Y: begin
                        phase_next    = PH_HEAD;
                        col_next      = col_new;
                        row_next      = row_new;
                        q_push        = 1'b1;
                        q_cmd.kind    = CMD_PKT;
                        q_cmd.idx     = idx_new;
                        q_cmd.col     = col_new;
                        q_cmd.row     = row_new;
                        q_cmd.buttons = header_reg[2:0];
                    end
                    default: begin
                        // A header must carry bit 3; anything else is dropped.
                        if (mouse_b[3]) begin
                            header_next = mouse_b;
                            phase_next  = PH_X;
                        end else begin
                            phase_next = PH_HEAD;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD;
            header_reg <= '0;
            xbyte_reg  <= '0;
            col_reg    <= COL_RESET;
            row_reg    <= ROW_RESET;
        end else begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            xbyte_reg  <= xbyte_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

[design/ps2mtc_fifo.sv]
// Short command queue between the front end and the back end.
// Depends on ps2mtc_pkg.

module ps2mtc_fifo import ps2mtc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/ps2mtc_back.sv]
// Back end: clears the text store after reset, then carries out queued host
// writes and cursor commands and emits each cursor cell write.
// Depends on ps2mtc_pkg and ps2mtc_ram.

module ps2mtc_back import ps2mtc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                head,
    input  q_status_t           q_status,
    output logic                pop,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    output logic                clear_busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_RESTORE = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_MODIFY  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  saved_idx_reg, saved_idx_next;
    logic [WORD_W-1:0] saved_cell_reg, saved_cell_next;
    logic [7:0]        paint_reg;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    cmd_t              out_cmd_reg, out_cmd_next;
    logic              out_last_reg, out_last_next;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic              out_free, no_button;
    logic [7:0]        attr;

    ps2mtc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // The output register may be reloaded in the cycle its word is taken.
    assign out_free   = !out_valid_reg || m_tready;
    assign no_button  = !cmd_reg.buttons[0] && !cmd_reg.buttons[1];
    assign attr       = cmd_reg.buttons[0] ? paint_reg : RIGHT_ATTR;
    assign clear_busy = (state_reg == ST_CLEAR);

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cmd_next        = cmd_reg;
        saved_idx_next  = saved_idx_reg;
        saved_cell_next = saved_cell_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_idx_next    = out_idx_reg;
        out_word_next   = out_word_reg;
        out_cmd_next    = out_cmd_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = cmd_reg.idx;
        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = BLANK_CELL;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop      = 1'b1;
                    cmd_next = head;
                    if (head.kind == CMD_HOST) begin
                        ram_we    = (int'(head.idx) < CELL_COUNT);
                        ram_waddr = head.idx;
                        ram_wdata = head.word;
                    end else if (head.buttons[0] || head.buttons[1]) begin
                        ram_re     = 1'b1;
                        ram_raddr  = head.idx;
                        state_next = ST_MODIFY;
                    end else begin
                        state_next = ST_RESTORE;
                    end
                end
            end
            ST_RESTORE: begin
                if (out_free) begin
                    ram_we         = 1'b1;
                    ram_waddr      = saved_idx_reg;
                    ram_wdata      = saved_cell_reg;
                    out_valid_next = 1'b1;
                    out_idx_next   = saved_idx_reg;
                    out_word_next  = saved_cell_reg;
                    out_cmd_next   = cmd_reg;
                    out_last_next  = 1'b0;
                    state_next     = ST_READ;
                end
            end
            ST_READ: begin
                ram_re     = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (out_free) begin
                    ram_we         = 1'b1;
                    ram_waddr      = cmd_reg.idx;
                    out_valid_next = 1'b1;
                    out_idx_next   = cmd_reg.idx;
                    out_cmd_next   = cmd_reg;
                    out_last_next  = 1'b1;
                    if (no_button) begin
                        ram_wdata       = CURSOR_CELL;
                        saved_idx_next  = cmd_reg.idx;
                        saved_cell_next = ram_rdata;
                    end else begin
                        ram_wdata = {attr, ram_rdata[7:0]};
                    end
                    out_word_next = ram_wdata;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        out_idx_reg  <= out_idx_next;
        out_word_reg <= out_word_next;
        out_cmd_reg  <= out_cmd_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            saved_idx_reg  <= '0;
            saved_cell_reg <= BLANK_CELL;
            out_valid_reg  <= 1'b0;
            paint_reg      <= PAINT_RESET;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            saved_idx_reg  <= saved_idx_next;
            saved_cell_reg <= saved_cell_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we) begin
                paint_reg <= cfg_wdata;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b0, out_cmd_reg.buttons[2], out_cmd_reg.buttons[1],
                       out_cmd_reg.buttons[0], out_cmd_reg.row, out_cmd_reg.col,
                       out_word_reg, out_idx_reg};

endmodule

[design/ps2_mouse_text_cursor.sv]
// PS/2 mouse text cursor. The front end takes one word per cycle while the command
// queue is not full and no clearing pass runs. Header and X bytes end in the front
// end; the back end does a host write from its idle state, a packet with a button
// held as a read-modify-write of the text store, and a packet without one by writing
// back the saved cell, then saving the new cell and writing the cursor cell there.
// After reset a clearing pass blanks every cell; no word is taken until it ends.

module ps2_mouse_text_cursor import ps2mtc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,   // paint_attribute
    input  logic                s_tvalid,
    output logic                s_tready,
    // mouse_byte[7:0], host_cell_index[18:8], host_cell_word[34:19], zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,     // func
    output logic                m_tvalid,
    input  logic                m_tready,
    // write_index[10:0], write_word[26:11], cursor_col[33:27], cursor_row[39:34],
    // left_button[40], right_button[41], middle_button[42], zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast      // last_write
);

    q_status_t q_status;
    cmd_t      q_cmd, q_head;
    logic      q_push, q_pop;
    logic      back_clear;

    ps2mtc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_status   (q_status),
        .clear_busy (back_clear),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    ps2mtc_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    ps2mtc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .q_status   (q_status),
        .pop        (q_pop),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .clear_busy (back_clear),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // No word may be taken while the text store is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        back_clear |-> !s_tready)
        else $error("input word accepted during clearing pass");

    // The queue never takes a command when it is full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !q_push)
        else $error("command queue overflow");

    // Nothing can be queued before the clearing pass has finished.
    a_empty_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(back_clear) |-> q_status.empty)
        else $error("command queued during clearing pass");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule
